@@ src/asp_pkg.sv @@
// Shared types and constants for the ASCII sensor line parser.
package asp_pkg;

  // Default line buffer capacity in bytes
  localparam int LINE_CAPACITY_DEF = 64;

  // Clamp limit of the reported reading
  localparam logic [12:0] PPM_MAX = 13'd5000;

  // Reset value of the report interval register
  localparam logic [15:0] REPORT_INTERVAL_RST = 16'd300;

  // Item kinds carried on in_tuser
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Special characters
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VTAB  = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // One input item as held in the input register
  typedef struct packed {
    logic       op;
    logic [7:0] byte_value;
  } item_t;

  // Outcome of a line end, from the parser to the throttle
  typedef struct packed {
    logic        valid;   // newline ends a line with a parsed number
    logic [12:0] ppm;     // clamped value of the line
  } line_res_t;

  // Parser phases, one-hot
  typedef enum logic [4:0] {
    PH_LEAD      = 5'b00001,
    PH_SIGN      = 5'b00010,
    PH_DIGITS    = 5'b00100,
    PH_DONE_OK   = 5'b01000,
    PH_DONE_FAIL = 5'b10000
  } phase_t;

endpackage

@@ src/asp_parse.sv @@
// Line assembler and on-the-fly decimal parser.
module asp_parse import asp_pkg::*; #(
  parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,      // process the held item this cycle
  input  item_t     item,
  output line_res_t line_res   // valid only for a newline byte
);

  localparam int LEN_W = (LINE_CAPACITY > 2) ? $clog2(LINE_CAPACITY) : 1;
  localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LINE_CAPACITY - 1);

  logic [LEN_W-1:0] line_length_r, line_length_nxt;
  phase_t           phase_r, phase_nxt;
  logic             neg_r, neg_nxt;
  logic [12:0]      acc_r, acc_nxt;

  logic [7:0]  c;
  logic        is_byte, is_cr, is_lf, is_digit, is_space;
  logic [3:0]  digit_val;
  logic [16:0] acc_x10;

  assign c         = item.byte_value;
  assign is_byte   = (item.op == OP_BYTE);
  assign is_cr     = (c == CH_CR);
  assign is_lf     = (c == CH_LF);
  assign is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_space  = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VTAB) || (c == CH_FF);
  assign digit_val = 4'(c - CH_ZERO);
  // acc * 10 + digit, at most 50009
  assign acc_x10   = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {13'd0, digit_val};

  // Line end result
  always_comb begin
    line_res.valid = is_byte && is_lf && ((phase_r == PH_DIGITS) || (phase_r == PH_DONE_OK));
    line_res.ppm   = neg_r ? 13'd0 : acc_r;
  end

  // Next parser state
  always_comb begin
    line_length_nxt = line_length_r;
    phase_nxt       = phase_r;
    neg_nxt         = neg_r;
    acc_nxt         = acc_r;
    if (is_byte && !is_cr) begin
      if (is_lf || (line_length_r >= LEN_LIMIT)) begin
        // newline or overflow: restart the line
        line_length_nxt = '0;
        phase_nxt       = PH_LEAD;
        neg_nxt         = 1'b0;
        acc_nxt         = '0;
      end else begin
        line_length_nxt = line_length_r + 1'b1;
        unique case (phase_r)
          PH_LEAD: begin
            if (is_space) begin
              phase_nxt = PH_LEAD;
            end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
              neg_nxt   = (c == CH_MINUS);
              phase_nxt = PH_SIGN;
            end else if (is_digit) begin
              acc_nxt   = {9'd0, digit_val};
              phase_nxt = PH_DIGITS;
            end else begin
              phase_nxt = PH_DONE_FAIL;
            end
          end
          PH_SIGN: begin
            if (is_digit) begin
              acc_nxt   = {9'd0, digit_val};
              phase_nxt = PH_DIGITS;
            end else begin
              phase_nxt = PH_DONE_FAIL;
            end
          end
          PH_DIGITS: begin
            if (is_digit) begin
              acc_nxt = (acc_x10 > {4'd0, PPM_MAX}) ? PPM_MAX : acc_x10[12:0];
            end else begin
              phase_nxt = PH_DONE_OK;
            end
          end
          PH_DONE_OK, PH_DONE_FAIL: begin
            phase_nxt = phase_r;
          end
          default: begin
            phase_nxt = PH_LEAD;
          end
        endcase
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_length_r <= '0;
      phase_r       <= PH_LEAD;
      neg_r         <= 1'b0;
      acc_r         <= '0;
    end else if (step) begin
      line_length_r <= line_length_nxt;
      phase_r       <= phase_nxt;
      neg_r         <= neg_nxt;
      acc_r         <= acc_nxt;
    end
  end

endmodule

@@ src/asp_throttle.sv @@
// Report interval register, seconds counter and report decision.
module asp_throttle import asp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        step,
  input  item_t       item,
  input  line_res_t   line_res,
  output logic        report       // emit line_res.ppm this step
);

  logic [15:0] interval_r;
  logic [15:0] secs_r, secs_nxt;
  logic        is_tick;

  assign is_tick = (item.op == OP_TICK);
  assign report  = line_res.valid && (secs_r >= interval_r);

  // Saturating second counter, cleared on a report
  always_comb begin
    secs_nxt = secs_r;
    if (is_tick) begin
      if (secs_r != 16'hFFFF) begin
        secs_nxt = secs_r + 16'd1;
      end
    end else if (report) begin
      secs_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= REPORT_INTERVAL_RST;
      secs_r     <= '0;
    end else begin
      if (cfg_wr_en) begin
        interval_r <= cfg_wr_data;
      end
      if (step) begin
        secs_r <= secs_nxt;
      end
    end
  end

endmodule

@@ src/ascii_sensor_line_parser.sv @@
// Top level of the ASCII sensor line parser.
//
// Input channel in_*: one transaction is either a received UART byte
// (in_tuser = 0, byte in in_tdata[7:0]) or a one-second tick (in_tuser = 1).
// Bytes build lines ending at newline; carriage returns are dropped. The
// first decimal integer of a line is clamped to 0..5000 and, at the newline,
// is sent on out_* if at least report_interval_s ticks have passed since the
// previous report. Configuration: cfg_wr_en writes cfg_wr_data into the
// interval register (reset value 300).
// An accepted newline passes the input register and then the result register
// before its result shows on out_*.
// Throughput: one transaction per cycle while no result waits or out_tready is
// high; the parser update between input and result registers is combinational.
// Reset (rst_n low, synchronous) empties both registers, restarts the line
// and clears the second counter.
// When out_tready is low with a result waiting, the held item stays in the
// input register and in_tready drops once that register is also full.
module ascii_sensor_line_parser import asp_pkg::*; #(
  parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] byte_value
  input  logic        in_tuser,    // [0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [12:0] ppm, [15:13] zero
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic        in_valid_r;
  item_t       item_r;
  logic        out_valid_r;
  logic [12:0] ppm_r;
  logic        step;
  logic        report;
  line_res_t   line_res;

  // Process the held item when the result register can take a result
  assign step      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.op         <= in_tuser;
      item_r.byte_value <= in_tdata;
    end
  end

  asp_parse #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .item     (item_r),
    .line_res (line_res)
  );

  asp_throttle u_throttle (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (step),
    .item        (item_r),
    .line_res    (line_res),
    .report      (report)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && report) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && report) begin
      ppm_r <= line_res.ppm;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, ppm_r};

endmodule

@@ tb/sv/ascii_sensor_line_parser_tb.sv @@
// Self-checking testbench for the ASCII sensor line parser.
module ascii_sensor_line_parser_tb;
  import asp_pkg::*;

  // Expectation codes for one stimulus line
  localparam int WANT_PREDICT = -1;  // take the value from the line predictor
  localparam int WANT_NONE    = -2;  // the newline must not report
  localparam int HOLD_CYCLES  = 200;
  localparam int PHASE_ITEMS  = 32;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;    // [7:0] byte_value
  logic        in_tuser = 1'b0;  // [0] op
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;        // [12:0] ppm, [15:13] zero
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  // Expectation that travels with the item on the input channel
  int          item_want = WANT_PREDICT;
  logic [12:0] reading_q[$];
  int          fail_count = 0;
  int          burst_left = 0;
  bit          hold_req = 1'b0;

  // Predictor state
  int          ln_len;
  phase_t      ph;
  bit          neg;
  logic [12:0] acc;
  logic [15:0] secs;
  logic [15:0] interval;

  // One directed line: optional register write, ticks, space padding, text
  typedef struct {
    int    cfg;
    int    ticks;
    int    pad;
    string text;
    int    want;
  } line_case_t;

  // A tilde in the text stands for a NUL byte
  line_case_t plan [27] = '{
    '{-1,     0,  0, "123\n",                  WANT_NONE},
    '{ 2,     1,  0, "5\n",                    WANT_NONE},
    '{-1,     1,  0, "42\n",                   42},
    '{ 0,     0,  0, "0\n",                    0},
    '{-1,     0,  0, "5000\n",                 5000},
    '{-1,     0,  0, "5001\n",                 5000},
    '{-1,     0,  0, "99999999\n",             5000},
    '{-1,     0,  0, "-7\n",                   0},
    '{-1,     0,  0, "-0\n",                   0},
    '{-1,     0,  0, "+12\n",                  12},
    '{-1,     0,  0, " \011\013\014+3x\n",     3},
    '{-1,     0,  0, "\0151\0152\015\n",       12},
    '{-1,     0,  0, "-\n",                    WANT_NONE},
    '{-1,     0,  0, "+\n",                    WANT_NONE},
    '{-1,     0,  0, "abc9\n",                 WANT_NONE},
    '{-1,     0,  0, "\n",                     WANT_NONE},
    '{-1,     0,  0, "12~34\n",                12},
    '{-1,     0,  0, "~5\n",                   WANT_NONE},
    '{-1,     0,  0, "7 8\n",                  7},
    '{-1,     0,  0, "--5\n",                  WANT_NONE},
    '{-1,     0, 61, "8\n",                    8},
    '{-1,     0, 62, "7\n",                    7},
    '{-1,     0, 63, "55\n",                   5},
    '{65535,  4,  0, "1\n",                    WANT_NONE},
    '{-1,     0,  0, "2\n",                    WANT_NONE},
    '{-1,     3,  0, "  -12 ppm\015\n",        WANT_PREDICT},
    '{ 1,     1,  0, "4321\n",                 WANT_PREDICT}
  };

  ascii_sensor_line_parser dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Line predictor
  function void clear_line();
    ln_len = 0;
    ph = PH_LEAD;
    neg = 1'b0;
    acc = '0;
  endfunction

  function bit predict_reading(input logic op, input logic [7:0] c, output logic [12:0] ppm);
    int v;
    bit ok;
    bit dig;
    ppm = '0;
    dig = (c >= CH_ZERO) && (c <= CH_NINE);
    if (op == OP_TICK) begin
      if (secs != 16'hFFFF) secs++;
      return 1'b0;
    end
    if (c == CH_CR) return 1'b0;
    if (c == CH_LF) begin
      ok = (ph == PH_DIGITS) || (ph == PH_DONE_OK);
      ppm = neg ? 13'd0 : acc;
      clear_line();
      if (ok && secs >= interval) begin
        secs = '0;
        return 1'b1;
      end
      return 1'b0;
    end
    // overflowing byte is dropped and the line starts over
    if (ln_len + 1 >= LINE_CAPACITY_DEF) begin
      clear_line();
      return 1'b0;
    end
    ln_len++;
    case (ph)
      PH_LEAD: begin
        if (c == CH_SPACE || c == CH_TAB || c == CH_VTAB || c == CH_FF) begin
          ph = PH_LEAD;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          neg = (c == CH_MINUS);
          ph = PH_SIGN;
        end else if (dig) begin
          acc = 13'(c - CH_ZERO);
          ph = PH_DIGITS;
        end else begin
          ph = PH_DONE_FAIL;
        end
      end
      PH_SIGN: begin
        if (dig) begin
          acc = 13'(c - CH_ZERO);
          ph = PH_DIGITS;
        end else begin
          ph = PH_DONE_FAIL;
        end
      end
      PH_DIGITS: begin
        if (dig) begin
          v = int'(acc) * 10 + int'(c - CH_ZERO);
          acc = (v > int'(PPM_MAX)) ? PPM_MAX : 13'(v);
        end else begin
          ph = PH_DONE_OK;
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // Input side: predict on every accepted transaction
  always @(posedge clk) begin
    logic [12:0] ppm;
    bit hit;
    if (rst_n && in_tvalid && in_tready) begin
      hit = predict_reading(in_tuser, in_tdata, ppm);
      if (item_want >= 0) reading_q.push_back(13'(item_want));
      else if (item_want == WANT_PREDICT && hit) reading_q.push_back(ppm);
    end
  end

  // Output side: compare with the oldest expected reading
  always @(posedge clk) begin
    logic [12:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (reading_q.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected reading %0d (raw 0x%04h)", $time, out_tdata[12:0], out_tdata);
      end else begin
        want = reading_q.pop_front();
        if (out_tdata !== {3'b000, want}) begin
          fail_count++;
          $display("%0t: reading mismatch, expected %0d, got %0d (raw 0x%04h)",
                   $time, want, out_tdata[12:0], out_tdata);
        end
      end
    end
  end

  // Receiver: stall pattern in modes of random length, plus one long hold-off
  initial begin : sink
    int mode;
    int left;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 2);
          left = $urandom_range(8, 80);
        end
        left--;
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Sender: one transaction, then a random gap at the end of each burst
  task automatic send_item(input logic op, input logic [7:0] b, input int want);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= b;
    item_want <= want;
    do @(posedge clk); while (!in_tready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 6);
      burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Register write once the block has drained
  task automatic set_interval(input logic [15:0] v);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (reading_q.size() != 0);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    interval = v;
  endtask

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(0, 3))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_VTAB;
      default: return CH_FF;
    endcase
  endfunction

  function automatic logic [7:0] digit_byte();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // Random line: mostly well-formed readings, some noise and over-long lines
  task automatic random_line(inout int count);
    logic [7:0] line_q[$];
    int kind;
    int k;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 8)) line_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      if (kind < 13) begin
        repeat ($urandom_range(55, 70))
          line_q.push_back($urandom_range(0, 1) ? blank_byte() : digit_byte());
      end else begin
        repeat ($urandom_range(0, 2)) line_q.push_back(blank_byte());
      end
      k = $urandom_range(0, 3);
      if (k == 1) line_q.push_back(CH_PLUS);
      else if (k == 2) line_q.push_back(CH_MINUS);
      repeat ($urandom_range(0, 5)) line_q.push_back(digit_byte());
      if ($urandom_range(0, 3) == 0) line_q.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 3) == 0) line_q.insert($urandom_range(0, line_q.size()), CH_CR);
    end
    // now and then two lines run together
    if ($urandom_range(0, 19) != 0) line_q.push_back(CH_LF);
    foreach (line_q[i]) begin
      send_item(OP_BYTE, line_q[i], WANT_PREDICT);
      if (line_q[i] != CH_CR) count++;
    end
  endtask

  // Main sequence
  initial begin : stim
    int i;
    int p;
    int sent;
    logic [7:0] c;
    int rand_iv[4];
    interval = REPORT_INTERVAL_RST;
    secs = '0;
    clear_line();
    rand_iv = '{0, 2, 1, 4};
    rand_iv[3] = $urandom_range(0, 5);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed lines
    foreach (plan[r]) begin
      if (plan[r].cfg >= 0) set_interval(16'(plan[r].cfg));
      repeat (plan[r].ticks) send_item(OP_TICK, 8'($urandom_range(0, 255)), WANT_PREDICT);
      repeat (plan[r].pad) send_item(OP_BYTE, CH_SPACE, WANT_PREDICT);
      for (i = 0; i < plan[r].text.len(); i++) begin
        c = plan[r].text[i];
        if (c == "~") c = 8'h00;
        send_item(OP_BYTE, c, (c == CH_LF) ? plan[r].want : WANT_PREDICT);
      end
    end

    // random phases, the first one under a long receiver hold-off
    for (p = 0; p < 4; p++) begin
      set_interval(16'(rand_iv[p]));
      if (p == 0) hold_req = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 2) == 0) begin
          repeat ($urandom_range(1, 3)) begin
            send_item(OP_TICK, 8'($urandom_range(0, 255)), WANT_PREDICT);
            sent++;
          end
        end
        random_line(sent);
      end
    end

    // drain
    in_tvalid <= 1'b0;
    do @(posedge clk); while (reading_q.size() != 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Run limit
  initial begin : watchdog
    #(20 * 2_000_000);
    $display("FAIL");
    $finish;
  end

endmodule
